// ===== design/assert_macros.svh =====
// Assertion macros for the engine RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// check that a condition implies another in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== design/pme_pkg.sv =====
// Package for the permutation mutation engine: sizes, codes and types
`default_nettype none

package pme_pkg;

   localparam int MAX_GENES  = 256;
   localparam int GENE_WIDTH = 64;
   localparam int IDX_WIDTH  = $clog2(MAX_GENES);
   localparam int LEN_WIDTH  = 9;
   localparam int POS_WIDTH  = 8;
   localparam int KIND_WIDTH = 3;
   localparam int DATA_WIDTH = 64;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;

   localparam logic [LEN_WIDTH-1:0] LEN_RESET = LEN_WIDTH'(256);
   localparam logic [LEN_WIDTH-1:0] LEN_MAX   = LEN_WIDTH'(MAX_GENES);

   localparam logic [KIND_WIDTH-1:0] KIND_LOAD     = 3'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_READ     = 3'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_INVERT   = 3'd2;
   localparam logic [KIND_WIDTH-1:0] KIND_INSERT   = 3'd3;
   localparam logic [KIND_WIDTH-1:0] KIND_EXCHANGE = 3'd4;
   localparam logic [KIND_WIDTH-1:0] KIND_SHIFT    = 3'd5;

   localparam logic STATUS_DONE    = 1'b0;
   localparam logic STATUS_INVALID = 1'b1;

   localparam int NUM_SEGS = 3;

   typedef struct packed {
      logic [IDX_WIDTH-1:0] lo;
      logic [IDX_WIDTH-1:0] hi;
   } seg_type;

endpackage

`default_nettype wire

// ===== design/pme_ram.sv =====
// Generic single-write, single-read RAM with registered read data
`default_nettype none

module pme_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/permutation_mutation_engine.sv =====
// One item is in work at a time. Load writes the gene store, read fetches a gene
// through the registered RAM read port, exchange does one swap and an invalid
// item goes straight to the response. Invert, insert and shift run as up to
// three segment reversals; each swap (states SW0 to SW3) uses the gene RAM's write and read ports.
// Reset is synchronous: it clears control state and sets active_length to 256;
// the gene store keeps its contents and needs no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module permutation_mutation_engine (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [pme_pkg::KIND_WIDTH-1:0]        req_kind,
   input  wire logic [pme_pkg::POS_WIDTH-1:0]         req_first_position,
   input  wire logic [pme_pkg::POS_WIDTH-1:0]         req_second_position,
   input  wire logic [pme_pkg::POS_WIDTH-1:0]         req_third_position,
   input  wire logic [pme_pkg::DATA_WIDTH-1:0]        req_gene_in,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic      [pme_pkg::DATA_WIDTH-1:0]        rsp_gene_out,
   output logic                                       rsp_status,
   input  wire logic                                  csr_psel,
   input  wire logic                                  csr_penable,
   input  wire logic                                  csr_pwrite,
   input  wire logic [pme_pkg::CSR_ADDR_WIDTH-1:0]    csr_paddr,
   input  wire logic [pme_pkg::CSR_DATA_WIDTH-1:0]    csr_pwdata,
   output logic      [pme_pkg::CSR_DATA_WIDTH-1:0]    csr_prdata,
   output logic                                       csr_pready
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_LOAD = 4'd1;
   localparam logic [3:0] ST_RD0  = 4'd2;
   localparam logic [3:0] ST_RD1  = 4'd3;
   localparam logic [3:0] ST_NEXT = 4'd4;
   localparam logic [3:0] ST_SW0  = 4'd5;
   localparam logic [3:0] ST_SW1  = 4'd6;
   localparam logic [3:0] ST_SW2  = 4'd7;
   localparam logic [3:0] ST_SW3  = 4'd8;
   localparam logic [3:0] ST_DONE = 4'd9;

   localparam int IW = pme_pkg::IDX_WIDTH;
   localparam int LW = pme_pkg::LEN_WIDTH;
   localparam int GW = pme_pkg::GENE_WIDTH;

   logic [LW-1:0]       active_length_ff, active_length_in;
   logic [3:0]          state_ff, state_in;
   logic [IW-1:0]       pos_ff, pos_in;
   logic [GW-1:0]       gene_ff, gene_in;
   logic [GW-1:0]       result_ff, result_in;
   logic                status_ff, status_in;
   logic [IW-1:0]       a_ff, a_in;
   logic [IW-1:0]       b_ff, b_in;
   logic [GW-1:0]       hold_ff, hold_in;
   logic                single_ff, single_in;
   logic [1:0]          seg_cnt_ff, seg_cnt_in;
   logic [1:0]          seg_idx_ff, seg_idx_in;
   pme_pkg::seg_type    seg_ff [pme_pkg::NUM_SEGS];
   pme_pkg::seg_type    seg_in [pme_pkg::NUM_SEGS];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [GW-1:0]       rsp_gene_ff, rsp_gene_in;
   logic                rsp_status_ff, rsp_status_in;

   logic [LW-1:0]       len;
   logic [LW-1:0]       p9, q9, r9;
   logic                p_ok, q_ok, pair_ok, invert_ok, shift_ok, item_ok;
   logic                req_xfer, csr_write;
   logic [IW-1:0]       a_inc, b_dec;

   logic                ram_we;
   logic [IW-1:0]       ram_waddr, ram_raddr;
   logic [GW-1:0]       ram_wdata, ram_rdata;

   pme_ram #(
      .WIDTH (GW),
      .DEPTH (pme_pkg::MAX_GENES)
   ) u_gene_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_prdata = csr_paddr[2] ? '0 : pme_pkg::CSR_DATA_WIDTH'(active_length_ff);

   always_comb begin
      active_length_in = active_length_ff;
      if (csr_write && !csr_paddr[2]) begin
         active_length_in = csr_pwdata[LW-1:0];
      end
   end

   assign len = (active_length_ff > pme_pkg::LEN_MAX) ? pme_pkg::LEN_MAX : active_length_ff;
   assign p9  = LW'(req_first_position);
   assign q9  = LW'(req_second_position);
   assign r9  = LW'(req_third_position);

   assign p_ok      = p9 < len;
   assign q_ok      = q9 < len;
   assign pair_ok   = p_ok && q_ok && (p9 != q9);
   assign invert_ok = ((p9 + LW'(2)) < len) && (q9 >= p9) && q_ok;
   assign shift_ok  = invert_ok && (r9 >= q9) && (r9 < len);

   always_comb begin
      case (req_kind)
         pme_pkg::KIND_LOAD:     item_ok = p_ok;
         pme_pkg::KIND_READ:     item_ok = p_ok;
         pme_pkg::KIND_INVERT:   item_ok = invert_ok;
         pme_pkg::KIND_INSERT:   item_ok = pair_ok;
         pme_pkg::KIND_EXCHANGE: item_ok = pair_ok;
         pme_pkg::KIND_SHIFT:    item_ok = shift_ok;
         default:                item_ok = 1'b0;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid & req_ready;
   assign a_inc     = a_ff + IW'(1);
   assign b_dec     = b_ff - IW'(1);

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      gene_in       = gene_ff;
      result_in     = result_ff;
      status_in     = status_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      hold_in       = hold_ff;
      single_in     = single_ff;
      seg_cnt_in    = seg_cnt_ff;
      seg_idx_in    = seg_idx_ff;
      seg_in        = seg_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_gene_in   = rsp_gene_ff;
      rsp_status_in = rsp_status_ff;
      ram_we        = 1'b0;
      ram_waddr     = a_ff;
      ram_wdata     = ram_rdata;
      ram_raddr     = a_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               pos_in     = req_first_position;
               gene_in    = req_gene_in[GW-1:0];
               result_in  = '0;
               status_in  = item_ok ? pme_pkg::STATUS_DONE : pme_pkg::STATUS_INVALID;
               single_in  = 1'b0;
               seg_idx_in = 2'd0;
               seg_cnt_in = 2'd0;
               a_in       = req_first_position;
               b_in       = req_second_position;
               if (!item_ok) begin
                  state_in = ST_DONE;
               end else begin
                  case (req_kind)
                     pme_pkg::KIND_LOAD: state_in = ST_LOAD;
                     pme_pkg::KIND_READ: state_in = ST_RD0;
                     pme_pkg::KIND_EXCHANGE: begin
                        single_in = 1'b1;
                        state_in  = ST_SW0;
                     end
                     pme_pkg::KIND_INVERT: begin
                        seg_in[0]  = '{lo: req_first_position, hi: req_second_position};
                        seg_cnt_in = 2'd1;
                        state_in   = ST_NEXT;
                     end
                     pme_pkg::KIND_INSERT: begin
                        if (req_second_position > req_first_position) begin
                           seg_in[0] = '{lo: req_first_position + IW'(1),
                                         hi: req_second_position};
                           seg_in[1] = '{lo: req_first_position, hi: req_second_position};
                        end else begin
                           seg_in[0] = '{lo: req_second_position,
                                         hi: req_first_position - IW'(1)};
                           seg_in[1] = '{lo: req_second_position, hi: req_first_position};
                        end
                        seg_cnt_in = 2'd2;
                        state_in   = ST_NEXT;
                     end
                     pme_pkg::KIND_SHIFT: begin
                        seg_in[0] = '{lo: req_first_position, hi: req_second_position};
                        seg_in[1] = '{lo: req_second_position + IW'(1),
                                      hi: req_third_position};
                        seg_in[2] = '{lo: req_first_position, hi: req_third_position};
                        seg_cnt_in = (req_third_position > req_second_position) ? 2'd3 : 2'd0;
                        state_in   = ST_NEXT;
                     end
                     default: state_in = ST_DONE;
                  endcase
               end
            end
         end
         ST_LOAD: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            ram_wdata = gene_ff;
            state_in  = ST_DONE;
         end
         ST_RD0: begin
            ram_raddr = pos_ff;
            state_in  = ST_RD1;
         end
         ST_RD1: begin
            result_in = ram_rdata;
            state_in  = ST_DONE;
         end
         ST_NEXT: begin
            if (seg_idx_ff == seg_cnt_ff) begin
               state_in = ST_DONE;
            end else begin
               a_in       = seg_ff[seg_idx_ff].lo;
               b_in       = seg_ff[seg_idx_ff].hi;
               seg_idx_in = seg_idx_ff + 2'd1;
               if (seg_ff[seg_idx_ff].lo < seg_ff[seg_idx_ff].hi) begin
                  state_in = ST_SW0;
               end
            end
         end
         ST_SW0: begin
            ram_raddr = a_ff;
            state_in  = ST_SW1;
         end
         ST_SW1: begin
            hold_in   = ram_rdata;
            ram_raddr = b_ff;
            state_in  = ST_SW2;
         end
         ST_SW2: begin
            ram_we    = 1'b1;
            ram_waddr = a_ff;
            ram_wdata = ram_rdata;
            state_in  = ST_SW3;
         end
         ST_SW3: begin
            ram_we    = 1'b1;
            ram_waddr = b_ff;
            ram_wdata = hold_ff;
            a_in      = a_inc;
            b_in      = b_dec;
            if (single_ff) begin
               state_in = ST_DONE;
            end else if (a_inc < b_dec) begin
               state_in = ST_SW0;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_gene_in   = result_ff;
               rsp_status_in = status_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_length_ff <= pme_pkg::LEN_RESET;
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         single_ff        <= 1'b0;
         seg_cnt_ff       <= 2'd0;
         seg_idx_ff       <= 2'd0;
      end else begin
         active_length_ff <= active_length_in;
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         single_ff        <= single_in;
         seg_cnt_ff       <= seg_cnt_in;
         seg_idx_ff       <= seg_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      gene_ff       <= gene_in;
      result_ff     <= result_in;
      status_ff     <= status_in;
      a_ff          <= a_in;
      b_ff          <= b_in;
      hold_ff       <= hold_in;
      seg_ff        <= seg_in;
      rsp_gene_ff   <= rsp_gene_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_gene_out = pme_pkg::DATA_WIDTH'(rsp_gene_ff);
   assign rsp_status   = rsp_status_ff;

   `ASSERT_IMPLIES(a_swap_order, clock, reset, state_ff == ST_SW0 && !single_ff, a_ff < b_ff)
   `ASSERT_IMPLIES(a_inv_zero, clock, reset, rsp_status == pme_pkg::STATUS_INVALID, ~|rsp_gene_out)
   `ASSERT_NEXT(a_xfer_busy, clock, reset, req_xfer, state_ff != ST_IDLE)
   `ASSERT_IMPLIES(a_we_state, clock, reset, ram_we, state_ff == ST_LOAD || state_ff >= ST_SW2)

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Testbench for the permutation mutation engine: mutations checked against a predictor
`timescale 1ns / 1ps

module testbench;

   localparam logic [pme_pkg::CSR_ADDR_WIDTH-1:0] ADDR_ACTIVE_LENGTH = 3'd0;
   localparam logic [pme_pkg::CSR_ADDR_WIDTH-1:0] ADDR_UNUSED        = 3'd4;
   localparam logic [pme_pkg::KIND_WIDTH-1:0]     KIND_UNKNOWN_LO    = 3'd6;
   localparam logic [pme_pkg::KIND_WIDTH-1:0]     KIND_UNKNOWN_HI    = 3'd7;
   localparam logic [pme_pkg::DATA_WIDTH-1:0]     GENE_ZERO          = '0;
   localparam logic [pme_pkg::DATA_WIDTH-1:0]     GENE_ONES          = '1;

   typedef struct {
      logic [pme_pkg::DATA_WIDTH-1:0] gene;
      logic                           status;
   } gene_answer_type;

   logic                               clock = 1'b0;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic [pme_pkg::KIND_WIDTH-1:0]     req_kind;
   logic [pme_pkg::POS_WIDTH-1:0]      req_first_position;
   logic [pme_pkg::POS_WIDTH-1:0]      req_second_position;
   logic [pme_pkg::POS_WIDTH-1:0]      req_third_position;
   logic [pme_pkg::DATA_WIDTH-1:0]     req_gene_in;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic [pme_pkg::DATA_WIDTH-1:0]     rsp_gene_out;
   logic                               rsp_status;
   logic                               csr_psel;
   logic                               csr_penable;
   logic                               csr_pwrite;
   logic [pme_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [pme_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [pme_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                               csr_pready;

   logic [pme_pkg::DATA_WIDTH-1:0]     chromosome [pme_pkg::MAX_GENES];
   logic [pme_pkg::LEN_WIDTH-1:0]      length_setting;
   gene_answer_type                    awaited_answers [$];
   gene_answer_type                    arrived_answer;
   int                                 error_count;
   bit                                 quiet_mode;

   permutation_mutation_engine uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_first_position  (req_first_position),
      .req_second_position (req_second_position),
      .req_third_position  (req_third_position),
      .req_gene_in         (req_gene_in),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_gene_out        (rsp_gene_out),
      .rsp_status          (rsp_status),
      .csr_psel            (csr_psel),
      .csr_penable         (csr_penable),
      .csr_pwrite          (csr_pwrite),
      .csr_paddr           (csr_paddr),
      .csr_pwdata          (csr_pwdata),
      .csr_prdata          (csr_prdata),
      .csr_pready          (csr_pready)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   task automatic rotate_genes(input int lo, input int hi, input int k);
      logic [pme_pkg::DATA_WIDTH-1:0] window [pme_pkg::MAX_GENES];
      int n;
      n = hi - lo + 1;
      for (int t = 0; t < n; t++) window[t] = chromosome[lo + t];
      for (int t = 0; t < n; t++) chromosome[lo + t] = window[(t + k) % n];
   endtask

   task automatic apply_mutation(input logic [pme_pkg::KIND_WIDTH-1:0] kind,
                                 input logic [pme_pkg::POS_WIDTH-1:0] first, second, third,
                                 input logic [pme_pkg::DATA_WIDTH-1:0] gene,
                                 output logic [pme_pkg::DATA_WIDTH-1:0] gene_out,
                                 output logic status);
      int len, p, q, r, a, b;
      logic [pme_pkg::DATA_WIDTH-1:0] held;
      logic ok;
      len = (length_setting > pme_pkg::LEN_MAX) ? pme_pkg::MAX_GENES : int'(length_setting);
      p = int'(first);
      q = int'(second);
      r = int'(third);
      gene_out = '0;
      ok = 1'b0;
      case (kind)
         pme_pkg::KIND_LOAD: begin
            if (p < len) begin
               chromosome[p] = gene;
               ok = 1'b1;
            end
         end
         pme_pkg::KIND_READ: begin
            if (p < len) begin
               gene_out = chromosome[p];
               ok = 1'b1;
            end
         end
         pme_pkg::KIND_INVERT: begin
            if (len >= 3 && p < len - 2 && q >= p && q < len) begin
               a = p;
               b = q;
               while (a < b) begin
                  held = chromosome[a];
                  chromosome[a] = chromosome[b];
                  chromosome[b] = held;
                  a++;
                  b--;
               end
               ok = 1'b1;
            end
         end
         pme_pkg::KIND_INSERT: begin
            if (p < len && q < len && p != q) begin
               if (q > p) rotate_genes(p, q, 1);
               else rotate_genes(q, p, p - q);
               ok = 1'b1;
            end
         end
         pme_pkg::KIND_EXCHANGE: begin
            if (p < len && q < len && p != q) begin
               held = chromosome[p];
               chromosome[p] = chromosome[q];
               chromosome[q] = held;
               ok = 1'b1;
            end
         end
         pme_pkg::KIND_SHIFT: begin
            if (len >= 3 && p < len - 2 && q >= p && q < len && r >= q && r < len) begin
               if (r > q) rotate_genes(p, r, q - p + 1);
               ok = 1'b1;
            end
         end
         default: ;
      endcase
      status = ok ? pme_pkg::STATUS_DONE : pme_pkg::STATUS_INVALID;
   endtask

   task automatic send_item(input logic [pme_pkg::KIND_WIDTH-1:0] kind,
                            input logic [pme_pkg::POS_WIDTH-1:0] first, second, third,
                            input logic [pme_pkg::DATA_WIDTH-1:0] gene);
      int gap;
      logic [pme_pkg::DATA_WIDTH-1:0] gene_out;
      logic status;
      gene_answer_type answer;
      gap = quiet_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_kind            <= kind;
      req_first_position  <= first;
      req_second_position <= second;
      req_third_position  <= third;
      req_gene_in         <= gene;
      do @(posedge clock); while (!req_ready);
      apply_mutation(kind, first, second, third, gene, gene_out, status);
      answer.gene   = gene_out;
      answer.status = status;
      awaited_answers.push_back(answer);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (awaited_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [pme_pkg::CSR_ADDR_WIDTH-1:0] addr,
                            input logic [pme_pkg::LEN_WIDTH-1:0] value);
      logic [pme_pkg::CSR_DATA_WIDTH-1:0] word;
      word = $urandom();
      word[pme_pkg::LEN_WIDTH-1:0] = value;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_ACTIVE_LENGTH) length_setting = value;
   endtask

   task automatic send_random_item();
      int span, roll, p, q, r;
      logic [pme_pkg::KIND_WIDTH-1:0] kind;
      span = (length_setting > pme_pkg::LEN_MAX) ? pme_pkg::MAX_GENES : int'(length_setting);
      roll = $urandom_range(0, 99);
      p = $urandom_range(0, span - 1);
      q = $urandom_range(0, span - 1);
      r = $urandom_range(0, span - 1);
      if (roll < 14) begin
         kind = pme_pkg::KIND_LOAD;
      end else if (roll < 32) begin
         kind = pme_pkg::KIND_READ;
      end else if (roll < 48) begin
         kind = pme_pkg::KIND_INVERT;
         p = $urandom_range(0, span - 3);
         q = $urandom_range(p, span - 1);
      end else if (roll < 63) begin
         kind = pme_pkg::KIND_INSERT;
         if (q == p) q = (p + 1) % span;
      end else if (roll < 77) begin
         kind = pme_pkg::KIND_EXCHANGE;
         if (q == p) q = (p + 1) % span;
      end else if (roll < 93) begin
         kind = pme_pkg::KIND_SHIFT;
         p = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, span - 3);
         q = $urandom_range(p, span - 1);
         r = ($urandom_range(0, 7) == 0) ? q : $urandom_range(q, span - 1);
      end else begin
         kind = pme_pkg::KIND_WIDTH'($urandom_range(0, 7));
         p = $urandom_range(0, 255);
         q = $urandom_range(0, 255);
         r = $urandom_range(0, 255);
      end
      send_item(kind, pme_pkg::POS_WIDTH'(p), pme_pkg::POS_WIDTH'(q), pme_pkg::POS_WIDTH'(r),
                {$urandom(), $urandom()});
   endtask

   task automatic test_fill_chromosome();
      for (int i = 0; i < pme_pkg::MAX_GENES; i++)
         send_item(pme_pkg::KIND_LOAD, pme_pkg::POS_WIDTH'(i), 8'($urandom()),
                   8'($urandom()), {$urandom(), $urandom()});
   endtask

   task automatic test_edge_positions();
      send_item(pme_pkg::KIND_LOAD, 8'd0, 8'd0, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_LOAD, 8'd255, 8'd255, 8'd255, GENE_ONES);
      send_item(pme_pkg::KIND_READ, 8'd0, 8'd0, 8'd0, GENE_ONES);
      send_item(pme_pkg::KIND_READ, 8'd255, 8'd0, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_INVERT, 8'd0, 8'd255, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_READ, 8'd0, 8'd0, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_INVERT, 8'd253, 8'd255, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_INVERT, 8'd254, 8'd255, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_INVERT, 8'd10, 8'd9, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_INVERT, 8'd7, 8'd7, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_INSERT, 8'd0, 8'd255, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_INSERT, 8'd255, 8'd0, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_INSERT, 8'd5, 8'd5, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_EXCHANGE, 8'd0, 8'd255, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_EXCHANGE, 8'd9, 8'd9, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_SHIFT, 8'd0, 8'd10, 8'd255, GENE_ZERO);
      send_item(pme_pkg::KIND_SHIFT, 8'd253, 8'd254, 8'd255, GENE_ZERO);
      send_item(pme_pkg::KIND_SHIFT, 8'd4, 8'd9, 8'd9, GENE_ZERO);
      send_item(pme_pkg::KIND_SHIFT, 8'd4, 8'd9, 8'd8, GENE_ZERO);
      send_item(pme_pkg::KIND_SHIFT, 8'd9, 8'd4, 8'd20, GENE_ZERO);
      send_item(pme_pkg::KIND_SHIFT, 8'd254, 8'd254, 8'd255, GENE_ZERO);
      send_item(pme_pkg::KIND_READ, 8'd128, 8'd0, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_READ, 8'd1, 8'd0, 8'd0, GENE_ZERO);
   endtask

   task automatic test_unknown_kinds();
      send_item(KIND_UNKNOWN_LO, 8'd1, 8'd2, 8'd3, GENE_ONES);
      send_item(KIND_UNKNOWN_HI, 8'd0, 8'd255, 8'd255, GENE_ONES);
      send_item(pme_pkg::KIND_READ, 8'd0, 8'd0, 8'd0, GENE_ZERO);
   endtask

   task automatic test_length_limits();
      drain_results();
      csr_write(ADDR_ACTIVE_LENGTH, 9'd0);
      send_item(pme_pkg::KIND_LOAD, 8'd0, 8'd0, 8'd0, GENE_ONES);
      send_item(pme_pkg::KIND_READ, 8'd0, 8'd0, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_EXCHANGE, 8'd0, 8'd1, 8'd0, GENE_ZERO);
      drain_results();
      csr_write(ADDR_ACTIVE_LENGTH, 9'd1);
      send_item(pme_pkg::KIND_READ, 8'd0, 8'd0, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_INSERT, 8'd0, 8'd1, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_INVERT, 8'd0, 8'd0, 8'd0, GENE_ZERO);
      drain_results();
      csr_write(ADDR_ACTIVE_LENGTH, 9'd2);
      send_item(pme_pkg::KIND_EXCHANGE, 8'd0, 8'd1, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_INVERT, 8'd0, 8'd1, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_SHIFT, 8'd0, 8'd0, 8'd1, GENE_ZERO);
      send_item(pme_pkg::KIND_READ, 8'd1, 8'd0, 8'd0, GENE_ZERO);
      drain_results();
      csr_write(ADDR_ACTIVE_LENGTH, 9'd511);
      send_item(pme_pkg::KIND_READ, 8'd255, 8'd0, 8'd0, GENE_ZERO);
      send_item(pme_pkg::KIND_SHIFT, 8'd253, 8'd254, 8'd255, GENE_ZERO);
      send_item(pme_pkg::KIND_INVERT, 8'd0, 8'd255, 8'd0, GENE_ZERO);
      drain_results();
      csr_write(ADDR_UNUSED, 9'd3);
      send_item(pme_pkg::KIND_READ, 8'd255, 8'd0, 8'd0, GENE_ZERO);
   endtask

   task automatic test_random_mix(input logic [pme_pkg::LEN_WIDTH-1:0] length,
                                  input int count, input bit steady);
      drain_results();
      csr_write(ADDR_ACTIVE_LENGTH, length);
      quiet_mode = steady;
      repeat (count) send_random_item();
      drain_results();
      quiet_mode = 1'b0;
   endtask

   initial begin
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         int stall;
         stall = quiet_mode ? 0 : pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_answers.size() == 0) begin
            $display("%0t: result with none awaited, gene_out %h status %b",
                     $time, rsp_gene_out, rsp_status);
            error_count++;
         end else begin
            arrived_answer = awaited_answers.pop_front();
            if (rsp_gene_out !== arrived_answer.gene) begin
               $display("%0t: gene_out expected %h actual %h",
                        $time, arrived_answer.gene, rsp_gene_out);
               error_count++;
            end
            if (rsp_status !== arrived_answer.status) begin
               $display("%0t: status expected %b actual %b",
                        $time, arrived_answer.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   initial begin
      #200_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_kind            = '0;
      req_first_position  = '0;
      req_second_position = '0;
      req_third_position  = '0;
      req_gene_in         = '0;
      csr_psel            = 1'b0;
      csr_penable         = 1'b0;
      csr_pwrite          = 1'b0;
      csr_paddr           = '0;
      csr_pwdata          = '0;
      quiet_mode          = 1'b0;
      error_count         = 0;
      length_setting      = pme_pkg::LEN_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_fill_chromosome();
      test_edge_positions();
      test_unknown_kinds();
      test_length_limits();
      test_random_mix(9'd8, 300, 1'b0);
      test_random_mix(9'd3, 174, 1'b0);
      test_random_mix(9'd256, 200, 1'b0);
      test_random_mix(9'd37, 400, 1'b1);
      test_random_mix(9'd300, 80, 1'b0);
      test_random_mix(9'd130, 150, 1'b0);
      test_random_mix(9'd16, 250, 1'b0);
      drain_results();
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
